[sv/oaatbh_pkg.sv]
package oaatbh_pkg;

	// Shift amounts of the per-byte mixing step.
	localparam int unsigned MIX_SHL = 10;
	localparam int unsigned MIX_SHR = 6;

	// Shift amounts of the three finalization steps.
	localparam int unsigned FIN_SHL_A = 3;
	localparam int unsigned FIN_SHR_B = 11;
	localparam int unsigned FIN_SHL_C = 15;

	localparam int unsigned HASH_W   = 32;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned BUCKET_W = 16;

	// Bucket count after reset.
	localparam logic [BUCKET_W-1:0] BUCKET_COUNT_RESET = 16'd67;

	// One finished key as it travels from the front end to the back end.
	typedef struct packed {
		logic [HASH_W-1:0]   mixed_hash;
		logic [BUCKET_W-1:0] bucket_count;
	} key_entry_t;

endpackage

[sv/oaatbh_front.sv]
module oaatbh_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [oaatbh_pkg::BYTE_W-1:0]    key_byte,
	input  logic                             last_byte,
	input  logic [oaatbh_pkg::BUCKET_W-1:0]  bucket_count,
	output logic                             push_valid,
	input  logic                             push_ready,
	output oaatbh_pkg::key_entry_t           push_entry
);

	logic [oaatbh_pkg::HASH_W-1:0] hash_q;
	logic [oaatbh_pkg::HASH_W-1:0] sum_byte;
	logic [oaatbh_pkg::HASH_W-1:0] sum_shift;
	logic [oaatbh_pkg::HASH_W-1:0] mixed;
	logic                          accept;

	// The front end stalls only while the queue has no room for a finished key.
	assign in_ready = push_ready;
	assign accept   = in_valid && in_ready;

	// Per-byte mixing: add the byte, add the hash shifted left, fold in the high bits.
	always_comb begin
		sum_byte  = hash_q + {{(oaatbh_pkg::HASH_W-oaatbh_pkg::BYTE_W){1'b0}}, key_byte};
		sum_shift = sum_byte + (sum_byte << oaatbh_pkg::MIX_SHL);
		mixed     = sum_shift ^ (sum_shift >> oaatbh_pkg::MIX_SHR);
	end

	// A transaction carrying the last byte hands the mixed hash to the queue.
	assign push_valid              = accept && last_byte;
	assign push_entry.mixed_hash   = mixed;
	assign push_entry.bucket_count = bucket_count;

	// Running hash; it restarts from zero after every key.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
		end else if (accept) begin
			hash_q <= last_byte ? '0 : mixed;
		end
	end

endmodule

[sv/oaatbh_queue.sv]
module oaatbh_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push_valid,
	output logic                   push_ready,
	input  oaatbh_pkg::key_entry_t push_entry,
	output logic                   pop_valid,
	input  logic                   pop_ready,
	output oaatbh_pkg::key_entry_t pop_entry
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	oaatbh_pkg::key_entry_t entries_q [DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [CNT_W-1:0]       count_q;
	logic                   do_push;
	logic                   do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[sv/oaatbh_back.sv]
module oaatbh_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pop_valid,
	output logic                             pop_ready,
	input  oaatbh_pkg::key_entry_t           pop_entry,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [oaatbh_pkg::HASH_W-1:0]    full_hash,
	output logic [oaatbh_pkg::BUCKET_W-1:0]  bucket_index
);

	localparam int unsigned DIV_W  = oaatbh_pkg::BUCKET_W + 1;
	localparam int unsigned STEP_W = $clog2(oaatbh_pkg::HASH_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(oaatbh_pkg::HASH_W - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIN_A,
		ST_FIN_B,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                           state_q;
	logic [oaatbh_pkg::HASH_W-1:0]    hash_q;
	logic [oaatbh_pkg::HASH_W-1:0]    quot_q;
	logic [oaatbh_pkg::BUCKET_W-1:0]  rem_q;
	logic [DIV_W-1:0]                 divisor_q;
	logic [STEP_W-1:0]                step_q;
	logic                             out_valid_q;
	logic [oaatbh_pkg::HASH_W-1:0]    full_hash_q;
	logic [oaatbh_pkg::BUCKET_W-1:0]  bucket_index_q;

	logic [oaatbh_pkg::HASH_W-1:0]    fin_a_sum;
	logic [oaatbh_pkg::HASH_W-1:0]    fin_a;
	logic [oaatbh_pkg::HASH_W-1:0]    fin_b;
	logic [DIV_W-1:0]                 rem_shift;
	logic [DIV_W-1:0]                 rem_diff;
	logic [oaatbh_pkg::BUCKET_W-1:0]  rem_next;
	logic                             out_free;

	assign pop_ready    = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign full_hash    = full_hash_q;
	assign bucket_index = bucket_index_q;
	assign out_free     = !out_valid_q || out_ready;

	// Finalization, split across the ST_FIN_A and ST_FIN_B states.
	always_comb begin
		fin_a_sum = hash_q + (hash_q << oaatbh_pkg::FIN_SHL_A);
		fin_a     = fin_a_sum ^ (fin_a_sum >> oaatbh_pkg::FIN_SHR_B);
		fin_b     = hash_q + (hash_q << oaatbh_pkg::FIN_SHL_C);
	end

	// One restoring division step: bring in the next dividend bit, subtract if it fits.
	always_comb begin
		rem_shift = {rem_q, quot_q[oaatbh_pkg::HASH_W-1]};
		rem_diff  = rem_shift - divisor_q;
		rem_next  = (rem_shift >= divisor_q) ? rem_diff[oaatbh_pkg::BUCKET_W-1:0]
		                                     : rem_shift[oaatbh_pkg::BUCKET_W-1:0];
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				hash_q <= pop_entry.mixed_hash;
				// A count of zero stands for 65536 buckets.
				divisor_q <= (pop_entry.bucket_count == '0)
				             ? {1'b1, {oaatbh_pkg::BUCKET_W{1'b0}}}
				             : {1'b0, pop_entry.bucket_count};
			end
			ST_FIN_A: begin
				hash_q <= fin_a;
			end
			ST_FIN_B: begin
				hash_q <= fin_b;
				quot_q <= fin_b;
				rem_q  <= '0;
			end
			ST_DIV: begin
				quot_q <= quot_q << 1;
				rem_q  <= rem_next;
			end
			default: begin
			end
		endcase
	end

	// Sequencer and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			step_q         <= '0;
			out_valid_q    <= 1'b0;
			full_hash_q    <= '0;
			bucket_index_q <= '0;
		end else begin
			// A finished key takes the output slot as soon as it is free.
			if (state_q == ST_DONE && out_free) begin
				out_valid_q    <= 1'b1;
				full_hash_q    <= hash_q;
				bucket_index_q <= rem_q;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						state_q <= ST_FIN_A;
					end
				end
				ST_FIN_A: begin
					state_q <= ST_FIN_B;
				end
				ST_FIN_B: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// Hold the result until the output slot is free.
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[sv/one_at_a_time_bucket_hash_core.sv]
// Byte-serial one-at-a-time hash with bucket reduction. Key bytes enter one per
// transaction and each accepted byte is mixed into the running hash; bytes are
// taken back to back while the queue has room. The byte flagged last_byte closes
// the key: its mixed hash and the bucket count in force at that moment go into a
// QUEUE_DEPTH-entry queue, and the running hash restarts at zero. A back end then
// finalizes the hash in its ST_FIN_A and ST_FIN_B states and reduces it modulo the
// bucket count with a restoring divider that retires one quotient bit per cycle;
// each key is taken from the queue, finalized, divided and handed off (held until
// the output slot is free) while the next keys stream in. Short keys are paced by
// the divider once the queue fills. Each key yields one result transaction carrying
// full_hash and bucket_index. A bucket count of zero is treated as 65536. The bucket
// count register resets to 67 and is written through cfg_wr_en/cfg_wr_data.
module one_at_a_time_bucket_hash_core #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [oaatbh_pkg::BUCKET_W-1:0]  cfg_wr_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [oaatbh_pkg::BYTE_W-1:0]    key_byte,
	input  logic                             last_byte,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [oaatbh_pkg::HASH_W-1:0]    full_hash,
	output logic [oaatbh_pkg::BUCKET_W-1:0]  bucket_index
);

	logic [oaatbh_pkg::BUCKET_W-1:0] bucket_count_q;
	logic                            push_valid;
	logic                            push_ready;
	oaatbh_pkg::key_entry_t          push_entry;
	logic                            pop_valid;
	logic                            pop_ready;
	oaatbh_pkg::key_entry_t          pop_entry;

	// Bucket count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= oaatbh_pkg::BUCKET_COUNT_RESET;
		end else if (cfg_wr_en) begin
			bucket_count_q <= cfg_wr_data;
		end
	end

	oaatbh_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.key_byte     (key_byte),
		.last_byte    (last_byte),
		.bucket_count (bucket_count_q),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_entry   (push_entry)
	);

	oaatbh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	oaatbh_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_entry    (pop_entry),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.full_hash    (full_hash),
		.bucket_index (bucket_index)
	);

endmodule
